// ----- rtl/core/ille_pkg.sv -----
// Shared types and constants for the indexed linked list engine.
// No dependencies.
`default_nettype none
package ille_pkg;
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 7;
    localparam int POS_W    = 7;
    localparam int KIND_W   = 4;
    localparam int STAT_W   = 2;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 4'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_INSERT     = 4'd4;
    localparam logic [KIND_W-1:0] KIND_REMOVE     = 4'd5;
    localparam logic [KIND_W-1:0] KIND_READ       = 4'd6;
    localparam logic [KIND_W-1:0] KIND_REVERSE    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] data;
    } link_wr_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } data_wr_t;
endpackage
`default_nettype wire

// ----- rtl/core/ille_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module ille_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/ille_ctrl.sv -----
// Command sequencer: walks links, allocates and frees entries, owns list registers.
// Depends on ille_pkg.
`default_nettype none
module ille_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ille_pkg::KIND_W-1:0]   kind,
    input  wire logic signed [ille_pkg::DATA_W-1:0] value,
    input  wire logic [ille_pkg::POS_W-1:0]    position,
    output logic                               busy,
    output logic                               done,
    output logic signed [ille_pkg::DATA_W-1:0] result_value,
    output logic [ille_pkg::STAT_W-1:0]        status,
    output logic [ille_pkg::CNT_W-1:0]         element_count,
    output logic                               is_empty,
    output logic [ille_pkg::ADDR_W-1:0]        rd_addr,
    input  wire logic [ille_pkg::DATA_W-1:0]   data_rd,
    input  wire logic [ille_pkg::ADDR_W-1:0]   fwd_rd,
    input  wire logic [ille_pkg::ADDR_W-1:0]   bwd_rd,
    output ille_pkg::data_wr_t                 data_wr,
    output ille_pkg::link_wr_t                 fwd_wr,
    output ille_pkg::link_wr_t                 bwd_wr
);
    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_STEP, S_GIVE, S_FREE, S_ALLOC, S_LINK
    } state_t;

    typedef enum logic [2:0] {
        OP_PUSH_F, OP_PUSH_B, OP_POP_F, OP_POP_B, OP_INS, OP_REM, OP_READ
    } op_t;

    state_t state_reg;
    op_t    op_reg;

    logic [ille_pkg::ADDR_W-1:0] head_reg, tail_reg, free_reg, cur_reg, before_reg, e_reg;
    logic [ille_pkg::CNT_W-1:0]  count_reg;
    logic [ille_pkg::POS_W-1:0]  pos_reg, step_reg;
    logic                        swap_reg;
    logic [ille_pkg::DATA_W-1:0] val_reg;
    logic [ille_pkg::CAPACITY-1:0] fwd_valid_reg;
    logic                        fwd_valid_q_reg;
    logic [ille_pkg::ADDR_W-1:0] rd_addr_q_reg;

    logic                        done_reg, empty_reg;
    logic [ille_pkg::DATA_W-1:0] res_reg;
    logic [ille_pkg::STAT_W-1:0] status_reg;
    logic [ille_pkg::CNT_W-1:0]  ecount_reg;

    logic [ille_pkg::ADDR_W-1:0] fwd_q, nxt_q, prv_q;
    ille_pkg::link_wr_t          nxt_w, prv_w, give_w;
    logic [ille_pkg::CNT_W-1:0]  count_inc, count_dec;
    logic                        start_at_tail, start_at_zero;

    // never-written free-chain links read as i+1
    assign fwd_q = fwd_valid_q_reg ? fwd_rd : rd_addr_q_reg + 1'b1;
    assign nxt_q = swap_reg ? bwd_rd : fwd_q;
    assign prv_q = swap_reg ? fwd_q : bwd_rd;
    assign count_inc = count_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;

    // pop back and remove of the last element start from the tail, no walk
    assign start_at_tail = (kind == ille_pkg::KIND_POP_BACK) ||
                           (kind == ille_pkg::KIND_REMOVE && position != '0 &&
                            position == count_dec);
    assign start_at_zero = start_at_tail || (kind == ille_pkg::KIND_POP_FRONT);

    assign rd_addr = (state_reg == S_FREE) ? free_reg : cur_reg;
    assign busy    = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign result_value  = res_reg;
    assign status        = status_reg;
    assign element_count = ecount_reg;
    assign is_empty      = empty_reg;

    always_comb
    begin
        nxt_w   = '0;
        prv_w   = '0;
        give_w  = '0;
        data_wr = '0;
        unique case (state_reg)
            S_STEP:
            begin
                if (step_reg == pos_reg)
                begin
                    if (op_reg == OP_POP_F || op_reg == OP_POP_B)
                    begin
                        give_w = '{we: 1'b1, addr: cur_reg, data: free_reg};
                    end
                    else if (op_reg == OP_REM)
                    begin
                        nxt_w = '{we: 1'b1, addr: prv_q, data: nxt_q};
                        prv_w = '{we: 1'b1, addr: nxt_q, data: prv_q};
                    end
                end
            end
            S_GIVE:
            begin
                give_w = '{we: 1'b1, addr: cur_reg, data: free_reg};
            end
            S_ALLOC:
            begin
                data_wr = '{we: 1'b1, addr: free_reg, data: val_reg};
                if (op_reg == OP_PUSH_F && count_reg != '0)
                begin
                    nxt_w = '{we: 1'b1, addr: free_reg, data: head_reg};
                    prv_w = '{we: 1'b1, addr: head_reg, data: free_reg};
                end
                else if (op_reg == OP_PUSH_B && count_reg != '0)
                begin
                    prv_w = '{we: 1'b1, addr: free_reg, data: tail_reg};
                    nxt_w = '{we: 1'b1, addr: tail_reg, data: free_reg};
                end
                else if (op_reg == OP_INS)
                begin
                    nxt_w = '{we: 1'b1, addr: free_reg, data: cur_reg};
                    prv_w = '{we: 1'b1, addr: free_reg, data: before_reg};
                end
            end
            S_LINK:
            begin
                nxt_w = '{we: 1'b1, addr: before_reg, data: e_reg};
                prv_w = '{we: 1'b1, addr: cur_reg, data: e_reg};
            end
            default:
            begin
            end
        endcase
        // logical next/prev map onto physical arrays by direction
        fwd_wr = give_w.we ? give_w : (swap_reg ? prv_w : nxt_w);
        bwd_wr = swap_reg ? nxt_w : prv_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_READ;
            head_reg        <= '0;
            tail_reg        <= '0;
            free_reg        <= '0;
            count_reg       <= '0;
            swap_reg        <= 1'b0;
            fwd_valid_reg   <= '0;
            fwd_valid_q_reg <= 1'b0;
            rd_addr_q_reg   <= '0;
            done_reg        <= 1'b0;
            res_reg         <= '0;
            status_reg      <= ille_pkg::ST_OK;
            ecount_reg      <= '0;
            empty_reg       <= 1'b1;
            cur_reg         <= '0;
            before_reg      <= '0;
            e_reg           <= '0;
            pos_reg         <= '0;
            step_reg        <= '0;
            val_reg         <= '0;
        end
        else
        begin
            rd_addr_q_reg   <= rd_addr;
            fwd_valid_q_reg <= fwd_valid_reg[rd_addr];
            if (fwd_wr.we)
            begin
                fwd_valid_reg[fwd_wr.addr] <= 1'b1;
            end
            done_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        val_reg  <= value;
                        pos_reg  <= start_at_zero ? '0 : position;
                        step_reg <= '0;
                        cur_reg  <= start_at_tail ? tail_reg : head_reg;
                        res_reg  <= '0;
                        status_reg <= ille_pkg::ST_OK;
                        ecount_reg <= count_reg;
                        empty_reg  <= (count_reg == '0);
                        case (kind) inside
                            ille_pkg::KIND_PUSH_FRONT, ille_pkg::KIND_PUSH_BACK:
                            begin
                                if (count_reg == ille_pkg::FULL_COUNT)
                                begin
                                    status_reg <= ille_pkg::ST_FULL;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    op_reg <= (kind == ille_pkg::KIND_PUSH_FRONT) ?
                                              OP_PUSH_F : OP_PUSH_B;
                                    state_reg <= S_FREE;
                                end
                            end
                            ille_pkg::KIND_POP_FRONT, ille_pkg::KIND_POP_BACK:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= ille_pkg::ST_EMPTY;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    op_reg <= (kind == ille_pkg::KIND_POP_FRONT) ?
                                              OP_POP_F : OP_POP_B;
                                    state_reg <= S_WALK;
                                end
                            end
                            ille_pkg::KIND_INSERT:
                            begin
                                if (position > count_reg)
                                begin
                                    status_reg <= ille_pkg::ST_RANGE;
                                    done_reg   <= 1'b1;
                                end
                                else if (count_reg == ille_pkg::FULL_COUNT)
                                begin
                                    status_reg <= ille_pkg::ST_FULL;
                                    done_reg   <= 1'b1;
                                end
                                else if (position == '0)
                                begin
                                    op_reg    <= OP_PUSH_F;
                                    state_reg <= S_FREE;
                                end
                                else if (position == count_reg)
                                begin
                                    op_reg    <= OP_PUSH_B;
                                    state_reg <= S_FREE;
                                end
                                else
                                begin
                                    op_reg    <= OP_INS;
                                    state_reg <= S_WALK;
                                end
                            end
                            ille_pkg::KIND_REMOVE, ille_pkg::KIND_READ:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= ille_pkg::ST_EMPTY;
                                    done_reg   <= 1'b1;
                                end
                                else if (position >= count_reg)
                                begin
                                    status_reg <= ille_pkg::ST_RANGE;
                                    done_reg   <= 1'b1;
                                end
                                else if (kind == ille_pkg::KIND_READ)
                                begin
                                    op_reg    <= OP_READ;
                                    state_reg <= S_WALK;
                                end
                                else if (position == '0)
                                begin
                                    op_reg    <= OP_POP_F;
                                    state_reg <= S_WALK;
                                end
                                else if (position == count_dec)
                                begin
                                    op_reg    <= OP_POP_B;
                                    state_reg <= S_WALK;
                                end
                                else
                                begin
                                    op_reg    <= OP_REM;
                                    state_reg <= S_WALK;
                                end
                            end
                            ille_pkg::KIND_REVERSE:
                            begin
                                swap_reg <= ~swap_reg;
                                head_reg <= tail_reg;
                                tail_reg <= head_reg;
                                done_reg <= 1'b1;
                            end
                            ille_pkg::KIND_CLEAR:
                            begin
                                swap_reg      <= 1'b0;
                                head_reg      <= '0;
                                tail_reg      <= '0;
                                free_reg      <= '0;
                                count_reg     <= '0;
                                fwd_valid_reg <= '0;
                                ecount_reg    <= '0;
                                empty_reg     <= 1'b1;
                                done_reg      <= 1'b1;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_WALK:
                begin
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    if (step_reg != pos_reg)
                    begin
                        cur_reg   <= nxt_q;
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= S_WALK;
                    end
                    else
                    begin
                        case (op_reg) inside
                            OP_READ:
                            begin
                                res_reg   <= data_rd;
                                done_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            OP_POP_F, OP_POP_B:
                            begin
                                if (count_reg > 7'd1)
                                begin
                                    if (op_reg == OP_POP_F)
                                    begin
                                        head_reg <= nxt_q;
                                    end
                                    else
                                    begin
                                        tail_reg <= prv_q;
                                    end
                                end
                                free_reg   <= cur_reg;
                                count_reg  <= count_dec;
                                res_reg    <= data_rd;
                                ecount_reg <= count_dec;
                                empty_reg  <= (count_dec == '0);
                                done_reg   <= 1'b1;
                                state_reg  <= S_IDLE;
                            end
                            OP_REM:
                            begin
                                val_reg   <= data_rd;
                                state_reg <= S_GIVE;
                            end
                            default:
                            begin
                                before_reg <= prv_q;
                                state_reg  <= S_FREE;
                            end
                        endcase
                    end
                end
                S_GIVE:
                begin
                    free_reg   <= cur_reg;
                    count_reg  <= count_dec;
                    res_reg    <= val_reg;
                    ecount_reg <= count_dec;
                    empty_reg  <= (count_dec == '0);
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                S_FREE:
                begin
                    state_reg <= S_ALLOC;
                end
                S_ALLOC:
                begin
                    free_reg  <= fwd_q;
                    e_reg     <= free_reg;
                    count_reg <= count_inc;
                    if (op_reg == OP_INS)
                    begin
                        state_reg <= S_LINK;
                    end
                    else
                    begin
                        if (op_reg == OP_PUSH_F)
                        begin
                            head_reg <= free_reg;
                            if (count_reg == '0)
                            begin
                                tail_reg <= free_reg;
                            end
                        end
                        else
                        begin
                            tail_reg <= free_reg;
                            if (count_reg == '0)
                            begin
                                head_reg <= free_reg;
                            end
                        end
                        ecount_reg <= count_inc;
                        empty_reg  <= 1'b0;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                S_LINK:
                begin
                    ecount_reg <= count_reg;
                    empty_reg  <= 1'b0;
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/indexed_linked_list_engine.sv -----
// Top level of the indexed linked list engine: sequencer plus element and link RAMs.
// Depends on ille_pkg, ille_ram, ille_ctrl.
//
// Usage:
//   A command word (kind, value, position) is taken at a rising edge where
//   start is high and busy is low. Exactly one result word comes back on
//   result_value/status/element_count/is_empty, valid for the single cycle
//   in which done is high. The receiver cannot stall; it must take it then.
// Steps (accept edge to done cycle):
//   reverse, clear, unknown kinds and all error cases finish straight from idle.
//   push front/back and insert at either end: free-chain read, then allocate
//   and link.
//   pop front/back, remove at either end: one entry read.
//   at position p: read, remove and insert first walk p hops; each hop is a
//   dependent read of the link RAMs (S_WALK, then S_STEP). Remove then frees the
//   entry (S_GIVE); insert reads the free chain, allocates and links (S_FREE,
//   S_ALLOC, S_LINK). busy is high from the accept until done is shown and stays low
//   for commands that finish straight from idle; a new command may be issued in the cycle done is shown.
// Reset: list empty, free chain runs through all entries (held as per-entry
//   valid bits over the forward links), no clearing pass needed. Element and
//   backward link RAMs are not initialized.
`default_nettype none
module indexed_linked_list_engine (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [ille_pkg::KIND_W-1:0]         kind,
    input  wire logic signed [ille_pkg::DATA_W-1:0]  value,
    input  wire logic [ille_pkg::POS_W-1:0]          position,
    output logic                                     done,
    output logic signed [ille_pkg::DATA_W-1:0]       result_value,
    output logic [ille_pkg::STAT_W-1:0]              status,
    output logic [ille_pkg::CNT_W-1:0]               element_count,
    output logic                                     is_empty
);
    logic [ille_pkg::ADDR_W-1:0] rd_addr;
    logic [ille_pkg::DATA_W-1:0] data_rd;
    logic [ille_pkg::ADDR_W-1:0] fwd_rd, bwd_rd;
    ille_pkg::data_wr_t          data_wr;
    ille_pkg::link_wr_t          fwd_wr, bwd_wr;

    ille_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .kind          (kind),
        .value         (value),
        .position      (position),
        .busy          (busy),
        .done          (done),
        .result_value  (result_value),
        .status        (status),
        .element_count (element_count),
        .is_empty      (is_empty),
        .rd_addr       (rd_addr),
        .data_rd       (data_rd),
        .fwd_rd        (fwd_rd),
        .bwd_rd        (bwd_rd),
        .data_wr       (data_wr),
        .fwd_wr        (fwd_wr),
        .bwd_wr        (bwd_wr)
    );

    // element words
    ille_ram #(.WIDTH(ille_pkg::DATA_W), .DEPTH(ille_pkg::CAPACITY)) u_data_ram (
        .clk   (clk),
        .we    (data_wr.we),
        .waddr (data_wr.addr),
        .wdata (data_wr.data),
        .raddr (rd_addr),
        .rdata (data_rd)
    );

    // forward links, also the free chain
    ille_ram #(.WIDTH(ille_pkg::ADDR_W), .DEPTH(ille_pkg::CAPACITY)) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_wr.we),
        .waddr (fwd_wr.addr),
        .wdata (fwd_wr.data),
        .raddr (rd_addr),
        .rdata (fwd_rd)
    );

    // backward links
    ille_ram #(.WIDTH(ille_pkg::ADDR_W), .DEPTH(ille_pkg::CAPACITY)) u_bwd_ram (
        .clk   (clk),
        .we    (bwd_wr.we),
        .waddr (bwd_wr.addr),
        .wdata (bwd_wr.data),
        .raddr (rd_addr),
        .rdata (bwd_rd)
    );

    // an accepted command always produces a result or keeps the engine busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted command neither busy nor done");

    // empty flag agrees with the count on every result
    a_empty_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (element_count == '0)))
        else $error("is_empty disagrees with element_count");

    // count never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> element_count <= ille_pkg::FULL_COUNT)
        else $error("element_count above capacity");

    // the strobe lasts a single cycle per command
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done || $past(start && !busy))
        else $error("done held without a new command");
endmodule
`default_nettype wire
